/* sv/pwd_pkg.sv */
package pwd_pkg;

    localparam int ByteW  = 8;
    localparam int FieldW = 29;
    localparam int ValW   = 64;
    localparam int IdxW   = 6;
    localparam int KindW  = 3;
    localparam int CfgW   = 6;

    localparam logic [KindW-1:0] KIND_VARINT  = 3'd0;
    localparam logic [KindW-1:0] KIND_FIX64   = 3'd1;
    localparam logic [KindW-1:0] KIND_HEADER  = 3'd2;
    localparam logic [KindW-1:0] KIND_PAYLOAD = 3'd3;
    localparam logic [KindW-1:0] KIND_FIX32   = 3'd4;
    localparam logic [KindW-1:0] KIND_ERROR   = 3'd5;
    localparam logic [KindW-1:0] KIND_END     = 3'd6;

    localparam logic [ValW-1:0] ERR_BADTYPE  = 64'd0;
    localparam logic [ValW-1:0] ERR_OVERLONG = 64'd1;
    localparam logic [ValW-1:0] ERR_TRUNC    = 64'd2;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_FIX64  = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_FIX32  = 3'd5;

    // classified input byte, passed from front to back
    typedef struct packed {
        logic [6:0]  low7;
        logic        cont;
        logic        last;
    } byte_item_t;

    typedef struct packed {
        logic [KindW-1:0]  kind;
        logic [FieldW-1:0] field_id;
        logic [ValW-1:0]   value;
        logic [IdxW-1:0]   field_index;
        logic              end_of_message;
    } result_t;

endpackage

/* sv/pwd_fifo.sv */
module pwd_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         is_full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         is_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign do_wr    = wr_en && !is_full;
    assign do_rd    = rd_en && !is_empty;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* sv/pwd_front.sv */
module pwd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output logic                full,
    input  logic                take,
    output pwd_pkg::byte_item_t item,
    output logic                item_valid
);
    import pwd_pkg::*;

    byte_item_t in_item;
    logic       q_empty;

    // split the continuation bit off the payload bits up front
    always_comb
    begin
        in_item.low7 = data_byte[6:0];
        in_item.cont = data_byte[7];
        in_item.last = last_byte;
    end

    pwd_fifo #(
        .W     ($bits(byte_item_t)),
        .DEPTH (2)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (in_item),
        .is_full  (full),
        .rd_en    (take),
        .rd_data  (item),
        .is_empty (q_empty)
    );

    assign item_valid = !q_empty;

endmodule

/* sv/pwd_back.sv */
module pwd_back #(
    parameter int LIM = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pwd_pkg::CfgW-1:0]    max_fields,
    input  pwd_pkg::byte_item_t         item,
    input  logic                        item_valid,
    output logic                        take,
    input  logic                        pop,
    output pwd_pkg::result_t            res,
    output logic                        empty
);
    import pwd_pkg::*;

    localparam int CntW = (LIM > 1) ? $clog2(LIM + 1) : 1;

    localparam logic [2:0] PH_KEY     = 3'd0;
    localparam logic [2:0] PH_VARINT  = 3'd1;
    localparam logic [2:0] PH_FIX64   = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_FIX32   = 3'd5;

    logic [2:0]        phase_reg, phase_next;
    logic [3:0]        step_reg, step_next;
    logic [ValW-1:0]   acc_reg, acc_next;
    logic [FieldW-1:0] cur_field_reg, cur_field_next;
    logic [ValW-1:0]   rem_reg, rem_next;
    logic [CntW-1:0]   done_reg, done_next;
    logic              halted_reg, halted_next;

    logic [CfgW-1:0]   limit;
    logic              ignore;
    logic [3:0]        step_inc;
    logic [6:0]        vshift;
    logic [ValW-1:0]   var_acc;
    logic [ValW-1:0]   fix_acc;
    logic [ValW-1:0]   rem_dec;
    logic [ByteW-1:0]  full_byte;
    logic              emit;
    result_t           out_res;
    logic              res_full;

    assign take      = item_valid && !res_full;
    assign full_byte = {item.cont, item.low7};
    assign limit     = (max_fields < CfgW'(LIM)) ? max_fields : CfgW'(LIM);
    assign ignore    = halted_reg || (phase_reg == PH_KEY && CfgW'(done_reg) >= limit);
    assign step_inc  = step_reg + 4'd1;
    assign vshift    = {step_reg, 3'b000} - {3'b000, step_reg};
    assign var_acc   = acc_reg | (ValW'(item.low7) << vshift);
    assign fix_acc   = acc_reg | (ValW'(full_byte) << {step_reg[2:0], 3'b000});
    assign rem_dec   = rem_reg - 64'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        cur_field_next = cur_field_reg;
        rem_next       = rem_reg;
        done_next      = done_reg;
        halted_next    = halted_reg;
        emit           = 1'b0;
        out_res.kind           = KIND_END;
        out_res.value          = '0;
        out_res.field_id       = '0;
        out_res.field_index    = IdxW'(done_reg);
        out_res.end_of_message = item.last;

        if (!ignore)
        begin
            unique case (phase_reg)
                PH_KEY, PH_VARINT, PH_LEN:
                begin
                    if (phase_reg == PH_KEY)
                    begin
                        cur_field_next = '0;
                    end
                    acc_next = var_acc;
                    if (item.cont)
                    begin
                        step_next = step_inc;
                        if (step_inc >= 4'd10)
                        begin
                            emit = 1'b1;
                            out_res.kind  = KIND_ERROR;
                            out_res.value = ERR_OVERLONG;
                            halted_next   = 1'b1;
                        end
                        else if (item.last)
                        begin
                            emit = 1'b1;
                            out_res.kind  = KIND_ERROR;
                            out_res.value = ERR_TRUNC;
                            halted_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        step_next = '0;
                        acc_next  = '0;
                        if (phase_reg == PH_KEY)
                        begin
                            cur_field_next = var_acc[FieldW+2:3];
                            unique case (var_acc[2:0])
                                WT_VARINT: phase_next = PH_VARINT;
                                WT_FIX64:  phase_next = PH_FIX64;
                                WT_LEN:    phase_next = PH_LEN;
                                WT_FIX32:  phase_next = PH_FIX32;
                                default:
                                begin
                                    emit = 1'b1;
                                    out_res.kind  = KIND_ERROR;
                                    out_res.value = ERR_BADTYPE;
                                    halted_next   = 1'b1;
                                end
                            endcase
                            if (!emit && item.last)
                            begin
                                phase_next    = PH_KEY;
                                emit          = 1'b1;
                                out_res.kind  = KIND_ERROR;
                                out_res.value = ERR_TRUNC;
                                halted_next   = 1'b1;
                            end
                        end
                        else if (phase_reg == PH_VARINT)
                        begin
                            emit          = 1'b1;
                            out_res.kind  = KIND_VARINT;
                            out_res.value = var_acc;
                            phase_next    = PH_KEY;
                            done_next     = done_reg + 1'b1;
                            rem_next      = '0;
                        end
                        else
                        begin
                            emit         = 1'b1;
                            out_res.kind = KIND_HEADER;
                            // zero length or length on the final byte closes the field
                            if (item.last || var_acc == '0)
                            begin
                                out_res.value = '0;
                                phase_next    = PH_KEY;
                                done_next     = done_reg + 1'b1;
                                rem_next      = '0;
                            end
                            else
                            begin
                                out_res.value = var_acc;
                                rem_next      = var_acc;
                                phase_next    = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_FIX64, PH_FIX32:
                begin
                    acc_next  = fix_acc;
                    step_next = step_inc;
                    if (step_inc >= ((phase_reg == PH_FIX64) ? 4'd8 : 4'd4))
                    begin
                        emit          = 1'b1;
                        out_res.kind  = (phase_reg == PH_FIX64) ? KIND_FIX64 : KIND_FIX32;
                        out_res.value = fix_acc;
                        phase_next    = PH_KEY;
                        step_next     = '0;
                        acc_next      = '0;
                        rem_next      = '0;
                        done_next     = done_reg + 1'b1;
                    end
                    else if (item.last)
                    begin
                        emit          = 1'b1;
                        out_res.kind  = KIND_ERROR;
                        out_res.value = ERR_TRUNC;
                        halted_next   = 1'b1;
                    end
                end
                PH_PAYLOAD:
                begin
                    emit          = 1'b1;
                    out_res.kind  = KIND_PAYLOAD;
                    out_res.value = ValW'(full_byte);
                    rem_next      = rem_dec;
                    if (rem_dec == '0 || item.last)
                    begin
                        phase_next = PH_KEY;
                        step_next  = '0;
                        acc_next   = '0;
                        rem_next   = '0;
                        done_next  = done_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (emit)
        begin
            out_res.field_id = cur_field_next;
        end

        if (item.last)
        begin
            emit        = 1'b1;
            phase_next  = PH_KEY;
            step_next   = '0;
            acc_next    = '0;
            cur_field_next = '0;
            rem_next    = '0;
            done_next   = '0;
            halted_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_KEY;
            step_reg      <= '0;
            acc_reg       <= '0;
            cur_field_reg <= '0;
            rem_reg       <= '0;
            done_reg      <= '0;
            halted_reg    <= 1'b0;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            acc_reg       <= acc_next;
            cur_field_reg <= cur_field_next;
            rem_reg       <= rem_next;
            done_reg      <= done_next;
            halted_reg    <= halted_next;
        end
    end

    pwd_fifo #(
        .W     ($bits(result_t)),
        .DEPTH (2)
    ) u_results (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (take && emit),
        .wr_data  (out_res),
        .is_full  (res_full),
        .rd_en    (pop),
        .rd_data  (res),
        .is_empty (empty)
    );

endmodule

/* sv/protobuf_wire_decoder_unit.sv */
// Streaming protobuf wire-format decoder. Push one buffer byte per cycle
// (last_byte marks the buffer's final byte); pop decoded field results from
// the result side. A two-entry input queue feeds the parse engine, which
// handles one byte per cycle and writes at most one result per byte into a
// two-entry result queue, so with pop held high the block sustains one byte
// per cycle; a byte waits in the input queue and its result is registered
// in the result queue. The engine stalls only while the result queue is full.
// Fields beyond min(max_fields, MAX_FIELDS), and all bytes after an error,
// are dropped; the final byte of a buffer always yields a result and resets
// the parse state. Write max_fields only while the block is idle.
module protobuf_wire_decoder_unit #(
    parameter int MAX_FIELDS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [pwd_pkg::ByteW-1:0]    data_byte,
    input  logic                         last_byte,
    output logic                         empty,
    input  logic                         pop,
    output logic [pwd_pkg::KindW-1:0]    kind,
    output logic [pwd_pkg::FieldW-1:0]   field_id,
    output logic [pwd_pkg::ValW-1:0]     value,
    output logic [pwd_pkg::IdxW-1:0]     field_index,
    output logic                         end_of_message,
    input  logic                         cfg_wr_en,
    input  logic [pwd_pkg::CfgW-1:0]     cfg_wr_data
);
    import pwd_pkg::*;

    // field count cannot exceed what the 6-bit register can ask for
    localparam int Lim = (MAX_FIELDS < 63) ? MAX_FIELDS : 63;

    logic [CfgW-1:0] max_fields_reg;
    byte_item_t      item;
    logic            item_valid;
    logic            take;
    result_t         res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_fields_reg <= 6'd32;
        end
        else if (cfg_wr_en)
        begin
            max_fields_reg <= cfg_wr_data;
        end
    end

    pwd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .full       (full),
        .take       (take),
        .item       (item),
        .item_valid (item_valid)
    );

    pwd_back #(
        .LIM (Lim)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_fields (max_fields_reg),
        .item       (item),
        .item_valid (item_valid),
        .take       (take),
        .pop        (pop),
        .res        (res),
        .empty      (empty)
    );

    assign kind           = res.kind;
    assign field_id       = res.field_id;
    assign value          = res.value;
    assign field_index    = res.field_index;
    assign end_of_message = res.end_of_message;

    a_end_has_eom: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_END) |-> end_of_message)
        else $error("end-only result without end_of_message");

    a_end_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_END) |-> (field_id == '0 && value == '0))
        else $error("end-only result carries field data");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (field_index <= IdxW'(Lim)))
        else $error("field_index above field limit");

    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_ERROR) |->
            (value == ERR_BADTYPE || value == ERR_OVERLONG || value == ERR_TRUNC))
        else $error("unknown error code");

endmodule

/* verif/protobuf_wire_decoder_unit_tb.sv */
module protobuf_wire_decoder_unit_tb;

    import pwd_pkg::*;

    localparam int DUT_MAX_FIELDS = 32;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int LONG_HOLD      = 400;

    localparam logic [2:0] WT_GROUP_START = 3'd3;
    localparam logic [2:0] WT_GROUP_END   = 3'd4;
    localparam logic [2:0] WT_RSVD6       = 3'd6;
    localparam logic [2:0] WT_RSVD7       = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_req_t;

    typedef enum logic [2:0] {
        WS_KEY,
        WS_VARINT,
        WS_FIX64,
        WS_LEN,
        WS_BODY,
        WS_FIX32
    } wire_state_t;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                push           = 1'b0;
    logic                full;
    logic [ByteW-1:0]    data_byte      = '0;
    logic                last_byte      = 1'b0;
    logic                empty;
    logic                pop            = 1'b0;
    logic [KindW-1:0]    kind;
    logic [FieldW-1:0]   field_id;
    logic [ValW-1:0]     value;
    logic [IdxW-1:0]     field_index;
    logic                end_of_message;
    logic                cfg_wr_en      = 1'b0;
    logic [CfgW-1:0]     cfg_wr_data    = '0;

    protobuf_wire_decoder_unit #(
        .MAX_FIELDS(DUT_MAX_FIELDS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .field_id       (field_id),
        .value          (value),
        .field_index    (field_index),
        .end_of_message (end_of_message),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    // decoder shadow state
    wire_state_t       ws;
    int                nbytes;
    logic [63:0]       acc_val;
    logic [FieldW-1:0] fnum;
    logic [2:0]        wtype;
    logic [63:0]       body_left;
    int                nfields;
    logic              stopped;
    int                fields_max = 32;

    result_t    decoded_q[$];
    byte_req_t  byte_reqs_q[$];
    logic [7:0] msg_q[$];

    int queued_bytes;
    int tx_mode;
    int rx_mode;
    int tx_gap;
    int rx_wait;
    int hold_left;
    int results_seen;
    int mismatches;
    int cycle_count;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void clear_parser();
        ws        = WS_KEY;
        nbytes    = 0;
        acc_val   = '0;
        fnum      = '0;
        wtype     = '0;
        body_left = '0;
        nfields   = 0;
        stopped   = 1'b0;
    endfunction

    function automatic void close_field();
        nfields++;
        ws        = WS_KEY;
        nbytes    = 0;
        acc_val   = '0;
        body_left = '0;
    endfunction

    function automatic result_t field_result(input logic [KindW-1:0] k, input logic [63:0] v);
        result_t r;
        r.kind           = k;
        r.field_id       = fnum;
        r.value          = v;
        r.field_index    = IdxW'(nfields);
        r.end_of_message = 1'b0;
        return r;
    endfunction

    // advance the shadow decoder by one byte and queue the result it causes
    function automatic void take_byte(input logic [7:0] b, input logic last);
        result_t     r;
        logic        got;
        logic [63:0] v;
        int          span;
        int          limit;
        got   = 1'b0;
        r     = '0;
        limit = (fields_max < DUT_MAX_FIELDS) ? fields_max : DUT_MAX_FIELDS;
        if (stopped || (ws == WS_KEY && nfields >= limit))
        begin
            // drop
        end
        else if (ws == WS_KEY || ws == WS_VARINT || ws == WS_LEN)
        begin
            if (ws == WS_KEY)
                fnum = '0;
            acc_val = acc_val | (64'(b[6:0]) << (7 * nbytes));
            if (b[7])
            begin
                nbytes++;
                if (nbytes >= 10)
                begin
                    r = field_result(KIND_ERROR, ERR_OVERLONG);
                    got = 1'b1;
                    stopped = 1'b1;
                end
                else if (last)
                begin
                    r = field_result(KIND_ERROR, ERR_TRUNC);
                    got = 1'b1;
                    stopped = 1'b1;
                end
            end
            else
            begin
                v       = acc_val;
                nbytes  = 0;
                acc_val = '0;
                if (ws == WS_KEY)
                begin
                    fnum  = v[31:3];
                    wtype = v[2:0];
                    if (wtype == WT_GROUP_START || wtype == WT_GROUP_END ||
                        wtype == WT_RSVD6 || wtype == WT_RSVD7)
                    begin
                        r = field_result(KIND_ERROR, ERR_BADTYPE);
                        got = 1'b1;
                        stopped = 1'b1;
                    end
                    else if (last)
                    begin
                        r = field_result(KIND_ERROR, ERR_TRUNC);
                        got = 1'b1;
                        stopped = 1'b1;
                    end
                    else if (wtype == WT_VARINT)
                        ws = WS_VARINT;
                    else if (wtype == WT_FIX64)
                        ws = WS_FIX64;
                    else if (wtype == WT_LEN)
                        ws = WS_LEN;
                    else
                        ws = WS_FIX32;
                end
                else if (ws == WS_VARINT)
                begin
                    r = field_result(KIND_VARINT, v);
                    got = 1'b1;
                    close_field();
                end
                else if (last || v == 0)
                begin
                    // length that ends the buffer or is zero closes the field at once
                    r = field_result(KIND_HEADER, '0);
                    got = 1'b1;
                    close_field();
                end
                else
                begin
                    r = field_result(KIND_HEADER, v);
                    got = 1'b1;
                    body_left = v;
                    ws = WS_BODY;
                end
            end
        end
        else if (ws == WS_FIX64 || ws == WS_FIX32)
        begin
            span    = (ws == WS_FIX64) ? 8 : 4;
            acc_val = acc_val | (64'(b) << (8 * nbytes));
            nbytes++;
            if (nbytes >= span)
            begin
                r = field_result((ws == WS_FIX64) ? KIND_FIX64 : KIND_FIX32, acc_val);
                got = 1'b1;
                close_field();
            end
            else if (last)
            begin
                r = field_result(KIND_ERROR, ERR_TRUNC);
                got = 1'b1;
                stopped = 1'b1;
            end
        end
        else
        begin
            r = field_result(KIND_PAYLOAD, 64'(b));
            got = 1'b1;
            body_left = body_left - 1;
            if (body_left == 0 || last)
                close_field();
        end

        if (last && !got)
        begin
            r = '0;
            r.kind = KIND_END;
            r.field_index = IdxW'(nfields);
            got = 1'b1;
        end
        if (got)
        begin
            r.end_of_message = last;
            decoded_q.push_back(r);
        end
        if (last)
            clear_parser();
    endfunction

    function automatic int draw_wait(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 19);
            default: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 19) : 0;
        endcase
    endfunction

    function automatic logic [63:0] rand_bits(input int w);
        logic [63:0] r;
        r = {$urandom, $urandom};
        if (w <= 0)
            return '0;
        return r >> (64 - w);
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int rand_pad();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
    endfunction

    // encode v in at least its minimal length plus pad bytes, ten at most
    function automatic void put_varint(input logic [63:0] v, input int pad);
        int n;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != 0)
            n++;
        n = n + pad;
        if (n > 10)
            n = 10;
        for (int i = 0; i < n; i++)
            msg_q.push_back({(i != n - 1), 7'(v >> (7 * i))});
    endfunction

    function automatic void put_key(input logic [2:0] wt);
        logic [63:0] fn;
        case ($urandom_range(0, 3))
            0:       fn = 64'($urandom_range(0, 15));
            1:       fn = rand_bits($urandom_range(1, 29));
            2:       fn = 64'h1FFF_FFFF;
            default: fn = rand_bits(61);
        endcase
        put_varint({fn[60:0], wt}, rand_pad());
    endfunction

    function automatic void put_field();
        int          len;
        logic [63:0] v;
        case ($urandom_range(0, 3))
            0:
            begin
                put_key(WT_VARINT);
                case ($urandom_range(0, 3))
                    0:       v = '1;
                    1:       v = 64'($urandom_range(0, 127));
                    default: v = rand_bits($urandom_range(0, 64));
                endcase
                put_varint(v, rand_pad());
            end
            1:
            begin
                put_key(WT_FIX64);
                for (int i = 0; i < 8; i++)
                    msg_q.push_back(rand_byte());
            end
            2:
            begin
                put_key(WT_LEN);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6);
                put_varint(64'(len), rand_pad());
                for (int i = 0; i < len; i++)
                    msg_q.push_back(rand_byte());
            end
            default:
            begin
                put_key(WT_FIX32);
                for (int i = 0; i < 4; i++)
                    msg_q.push_back(rand_byte());
            end
        endcase
    endfunction

    // mark the final byte and hand the buffer to the driver
    function automatic void send_buffer();
        if (msg_q.size() == 0)
            msg_q.push_back(rand_byte());
        foreach (msg_q[i])
            byte_reqs_q.push_back('{data: msg_q[i], last: (i == msg_q.size() - 1)});
        queued_bytes += msg_q.size();
        msg_q.delete();
    endfunction

    function automatic void build_buffer();
        int sel;
        int cut;
        int n;
        logic [2:0] bad_wt;
        sel = $urandom_range(0, 99);
        if (sel < 4)
        begin
            // long run of small fields to hit the field limit
            n = $urandom_range(30, 36);
            for (int i = 0; i < n; i++)
            begin
                put_key(WT_VARINT);
                put_varint(64'($urandom_range(0, 127)), 0);
            end
        end
        else if (sel < 60)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                put_field();
            if (sel >= 45)
            begin
                cut = $urandom_range(1, msg_q.size());
                while (msg_q.size() > cut)
                    void'(msg_q.pop_back());
            end
        end
        else if (sel < 72)
        begin
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++)
                put_field();
            case ($urandom_range(0, 3))
                0:       bad_wt = WT_GROUP_START;
                1:       bad_wt = WT_GROUP_END;
                2:       bad_wt = WT_RSVD6;
                default: bad_wt = WT_RSVD7;
            endcase
            put_key(bad_wt);
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
                msg_q.push_back(rand_byte());
        end
        else if (sel < 82)
        begin
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++)
                put_field();
            case ($urandom_range(0, 2))
                0:       ;
                1:       put_key(WT_VARINT);
                default: put_key(WT_LEN);
            endcase
            n = $urandom_range(10, 12);
            for (int i = 0; i < n; i++)
                msg_q.push_back({1'b1, 7'($urandom_range(0, 127))});
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
                msg_q.push_back(rand_byte());
        end
        else if (sel < 92)
        begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                msg_q.push_back(rand_byte());
        end
        else
        begin
            // buffer ends right after a complete key
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                put_field();
            case ($urandom_range(0, 3))
                0:       put_key(WT_VARINT);
                1:       put_key(WT_FIX64);
                2:       put_key(WT_LEN);
                default: put_key(WT_FIX32);
            endcase
        end
        send_buffer();
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want_v,
                                          input logic [63:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    // sender: one request per accepted byte, gap drawn per byte
    always @(posedge clk)
    begin : drive_proc
        logic      offer;
        byte_req_t nxt;
        if (!rst_n)
        begin
            push <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            offer = push;
            if (push && !full)
            begin
                take_byte(data_byte, last_byte);
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (byte_reqs_q.size() != 0)
                begin
                    nxt = byte_reqs_q.pop_front();
                    data_byte <= nxt.data;
                    last_byte <= nxt.last;
                    offer = 1'b1;
                    tx_gap = draw_wait(tx_mode);
                end
            end
            push <= offer;
        end
    end

    // receiver: check each popped result against the oldest prediction
    always @(posedge clk)
    begin : watch_proc
        logic    want;
        result_t exp_r;
        if (!rst_n)
        begin
            pop <= 1'b0;
            rx_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected result: kind %0d field %0d value 0x%0h",
                           kind, field_id, value);
                    mismatches++;
                end
                else
                begin
                    exp_r = decoded_q.pop_front();
                    compare_field("kind", 64'(exp_r.kind), 64'(kind));
                    compare_field("field_id", 64'(exp_r.field_id), 64'(field_id));
                    compare_field("value", exp_r.value, value);
                    compare_field("field_index", 64'(exp_r.field_index), 64'(field_index));
                    compare_field("end_of_message", 64'(exp_r.end_of_message),
                                  64'(end_of_message));
                end
                results_seen++;
                rx_wait = draw_wait(rx_mode);
                // hold off long enough for the input side to back up
                if (results_seen == 120 || results_seen == 700)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                want = 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                want = 1'b0;
            end
            else
                want = 1'b1;
            pop <= want;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** protobuf_wire_decoder_unit: FAILED **");
            $finish;
        end
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (byte_reqs_q.size() != 0 || push || decoded_q.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_max_fields(input int v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CfgW'(v);
        fields_max   = v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    initial
    begin
        int plan_fields[7];
        int plan_bytes[7];
        clear_parser();
        queued_bytes = 0;
        results_seen = 0;
        mismatches   = 0;
        cycle_count  = 0;
        tx_mode      = 0;
        rx_mode      = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed buffers at the reset field limit
        msg_q = '{8'h08, 8'h96, 8'h01, 8'h0D, 8'h00, 8'h00, 8'h00, 8'h80,
                  8'h12, 8'h02, 8'hFF, 8'h00, 8'h0B};
        send_buffer();
        msg_q = '{8'h0A, 8'h05};
        send_buffer();
        msg_q = '{8'h1A, 8'h03, 8'h41};
        send_buffer();
        msg_q = '{8'h80};
        send_buffer();
        msg_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'hFF, 8'hFF, 8'h07};
        send_buffer();
        wait_drained();

        plan_fields = '{32, 1, 63, 0, 0, 40, 5};
        plan_fields[4] = $urandom_range(2, 31);
        plan_bytes  = '{250, 120, 250, 40, 210, 210, 190};
        for (int p = 0; p < 7; p++)
        begin
            write_max_fields(plan_fields[p]);
            tx_mode = p % 3;
            rx_mode = (p + 2) % 3;
            queued_bytes = 0;
            if (plan_fields[p] == 0)
            begin
                msg_q = '{8'h08, 8'h01};
                send_buffer();
            end
            while (queued_bytes < plan_bytes[p])
                build_buffer();
            wait_drained();
        end

        if (mismatches == 0)
            $display("** protobuf_wire_decoder_unit: PASSED **");
        else
            $display("** protobuf_wire_decoder_unit: FAILED **");
        $finish;
    end

endmodule
